FILE: rtl/core/cnrf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cnrf_pkg;

	// Canvas geometry
	localparam int CANVAS_SIZE = 216;
	localparam int ROW_BYTES   = (CANVAS_SIZE + 1) / 2;
	localparam int STORE_DEPTH = CANVAS_SIZE * ROW_BYTES;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int COORD_W     = $clog2(CANVAS_SIZE + 1);

	// Word field widths
	localparam int IN_W    = 11;
	localparam int SUM_W   = IN_W + 1;
	localparam int NIB_W   = 4;
	localparam int BADDR_W = 15;
	localparam int KIND_W  = 2;
	localparam int DATA_W  = 8;

	// Command codes
	localparam logic ACT_FILL = 1'b0;
	localparam logic ACT_READ = 1'b1;

	// Acknowledge codes
	localparam logic [KIND_W-1:0] ACK_FILL_DONE  = 2'd0;
	localparam logic [KIND_W-1:0] ACK_FILL_EMPTY = 2'd1;
	localparam logic [KIND_W-1:0] ACK_READ_DATA  = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLIP,
		ST_SETUP,
		ST_WRITE,
		ST_RD_ISSUE,
		ST_DONE
	} cnrf_state_t;

	// Controller to datapath
	typedef struct packed {
		logic load;
		logic clip;
		logic setup;
		logic write;
		logic rd;
		logic push;
	} cnrf_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic is_read;
		logic empty;
		logic last_col;
		logic last_row;
		logic out_free;
	} cnrf_sts_t;

	// Clamp a signed coordinate into [0, CANVAS_SIZE]
	function automatic logic [COORD_W-1:0] clamp_coord(input logic signed [SUM_W-1:0] v);
		logic [COORD_W-1:0] r;
		if (v[SUM_W-1]) begin
			r = '0;
		end else if (v > $signed(SUM_W'(CANVAS_SIZE))) begin
			r = COORD_W'(CANVAS_SIZE);
		end else begin
			r = COORD_W'(v);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/cnrf_ram.sv
`timescale 1ns / 1ps
`default_nettype none

// Single-port RAM, registered read
module cnrf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[addr];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/cnrf_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module cnrf_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire cnrf_pkg::cnrf_sts_t sts,
	output cnrf_pkg::cnrf_cmd_t    cmd
);

	cnrf_pkg::cnrf_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cnrf_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cnrf_pkg::ST_IDLE: begin
				if (in_valid) state_d = cnrf_pkg::ST_CLIP;
			end
			cnrf_pkg::ST_CLIP: begin
				state_d = sts.is_read ? cnrf_pkg::ST_RD_ISSUE : cnrf_pkg::ST_SETUP;
			end
			cnrf_pkg::ST_SETUP: begin
				state_d = sts.empty ? cnrf_pkg::ST_DONE : cnrf_pkg::ST_WRITE;
			end
			cnrf_pkg::ST_WRITE: begin
				if (sts.last_col && sts.last_row) state_d = cnrf_pkg::ST_DONE;
			end
			cnrf_pkg::ST_RD_ISSUE: begin
				state_d = cnrf_pkg::ST_DONE;
			end
			cnrf_pkg::ST_DONE: begin
				if (sts.out_free) state_d = cnrf_pkg::ST_IDLE;
			end
			default: state_d = cnrf_pkg::ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			cnrf_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			cnrf_pkg::ST_CLIP:     cmd.clip  = 1'b1;
			cnrf_pkg::ST_SETUP:    cmd.setup = 1'b1;
			cnrf_pkg::ST_WRITE:    cmd.write = 1'b1;
			cnrf_pkg::ST_RD_ISSUE: cmd.rd    = 1'b1;
			cnrf_pkg::ST_DONE:     cmd.push  = sts.out_free;
			default: ;
		endcase
	end

	// Write loop only runs for a non-empty fill
	a_write_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == cnrf_pkg::ST_WRITE) |-> (!sts.empty && !sts.is_read))
		else $error("write loop on empty fill or read");

	// A read always takes the issue step right after clipping
	a_read_path: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == cnrf_pkg::ST_RD_ISSUE) |=> (state_q == cnrf_pkg::ST_DONE))
		else $error("read issue not followed by done");

	// Only one item in flight: accept only from idle
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == cnrf_pkg::ST_CLIP))
		else $error("accepted word did not start clipping");

endmodule

`default_nettype wire

FILE: rtl/core/cnrf_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module cnrf_datapath (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire cnrf_pkg::cnrf_cmd_t                    cmd,
	output cnrf_pkg::cnrf_sts_t                         sts,
	input  wire logic                                   action,
	input  wire logic signed [cnrf_pkg::IN_W-1:0]       left,
	input  wire logic signed [cnrf_pkg::IN_W-1:0]       top,
	input  wire logic signed [cnrf_pkg::IN_W-1:0]       width,
	input  wire logic signed [cnrf_pkg::IN_W-1:0]       height,
	input  wire logic        [cnrf_pkg::NIB_W-1:0]      colour,
	input  wire logic        [cnrf_pkg::BADDR_W-1:0]    byte_address,
	output logic                                        out_valid,
	input  wire logic                                   out_ready,
	output logic             [cnrf_pkg::KIND_W-1:0]     ack_kind,
	output logic             [cnrf_pkg::DATA_W-1:0]     read_data
);

	localparam int CW = cnrf_pkg::COORD_W;
	localparam int AW = cnrf_pkg::ADDR_W;
	localparam int SW = cnrf_pkg::SUM_W;

	// Command word
	logic                             is_read_q;
	logic signed [cnrf_pkg::IN_W-1:0] left_q, top_q, width_q, height_q;
	logic [cnrf_pkg::NIB_W-1:0]       colour_q;
	logic [AW-1:0]                    rd_addr_q;
	logic                             in_range_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			is_read_q  <= (action == cnrf_pkg::ACT_READ);
			left_q     <= left;
			top_q      <= top;
			width_q    <= width;
			height_q   <= height;
			colour_q   <= colour;
			rd_addr_q  <= AW'(byte_address);
			in_range_q <= (32'(byte_address) < 32'(cnrf_pkg::STORE_DEPTH));
		end
	end

	// Clip to canvas
	logic signed [SW-1:0] x_end, y_end;
	logic [CW-1:0]        x0_c, x1_c, y0_c, y1_c;
	logic                 neg_size;
	logic [CW-1:0]        x0_q, x1_q, y0_q, y1_q;
	logic                 empty_q;

	assign x_end    = $signed({left_q[cnrf_pkg::IN_W-1], left_q})
		+ $signed({width_q[cnrf_pkg::IN_W-1], width_q});
	assign y_end    = $signed({top_q[cnrf_pkg::IN_W-1], top_q})
		+ $signed({height_q[cnrf_pkg::IN_W-1], height_q});
	assign x0_c     = cnrf_pkg::clamp_coord($signed({left_q[cnrf_pkg::IN_W-1], left_q}));
	assign y0_c     = cnrf_pkg::clamp_coord($signed({top_q[cnrf_pkg::IN_W-1], top_q}));
	assign x1_c     = cnrf_pkg::clamp_coord(x_end);
	assign y1_c     = cnrf_pkg::clamp_coord(y_end);
	assign neg_size = width_q[cnrf_pkg::IN_W-1] || (width_q == '0)
		|| height_q[cnrf_pkg::IN_W-1] || (height_q == '0);

	always_ff @(posedge clk) begin
		if (cmd.clip) begin
			x0_q    <= x0_c;
			x1_q    <= x1_c;
			y0_q    <= y0_c;
			y1_q    <= y1_c;
			empty_q <= neg_size || (x0_c >= x1_c) || (y0_c >= y1_c);
		end
	end

	// Row and byte-column walk
	logic [CW-1:0] bx_first_q, bx_last_q, col_q, row_q;
	logic [AW-1:0] row_base_q;
	logic [CW-1:0] x1_m1;
	logic          last_col, last_row;

	assign x1_m1    = x1_q - CW'(1);
	assign last_col = (col_q == bx_last_q);
	assign last_row = ({1'b0, row_q} + (CW + 1)'(1)) == {1'b0, y1_q};

	always_ff @(posedge clk) begin
		if (cmd.setup) begin
			bx_first_q <= x0_q >> 1;
			bx_last_q  <= x1_m1 >> 1;
			col_q      <= x0_q >> 1;
			row_q      <= y0_q;
			row_base_q <= AW'(y0_q * cnrf_pkg::ROW_BYTES);
		end else if (cmd.write) begin
			if (last_col) begin
				col_q      <= bx_first_q;
				row_q      <= row_q + CW'(1);
				row_base_q <= row_base_q + AW'(cnrf_pkg::ROW_BYTES);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// Frame store: high and low nibble planes
	logic [AW-1:0]                 wr_addr, ram_addr;
	logic                          we_hi, we_lo;
	logic [cnrf_pkg::NIB_W-1:0]    rdata_hi, rdata_lo;

	assign wr_addr  = row_base_q + AW'(col_q);
	assign ram_addr = cmd.write ? wr_addr : rd_addr_q;
	// partial first byte at odd start, partial last byte at odd end
	assign we_hi    = cmd.write && !((col_q == bx_first_q) && x0_q[0]);
	assign we_lo    = cmd.write && !(last_col && x1_q[0]);

	cnrf_ram #(
		.WIDTH(cnrf_pkg::NIB_W),
		.DEPTH(cnrf_pkg::STORE_DEPTH)
	) u_ram_hi (
		.clk  (clk),
		.we   (we_hi),
		.re   (cmd.rd),
		.addr (ram_addr),
		.wdata(colour_q),
		.rdata(rdata_hi)
	);

	cnrf_ram #(
		.WIDTH(cnrf_pkg::NIB_W),
		.DEPTH(cnrf_pkg::STORE_DEPTH)
	) u_ram_lo (
		.clk  (clk),
		.we   (we_lo),
		.re   (cmd.rd),
		.addr (ram_addr),
		.wdata(colour_q),
		.rdata(rdata_lo)
	);

	// Output register
	logic                          out_valid_q;
	logic [cnrf_pkg::KIND_W-1:0]   ack_kind_q;
	logic [cnrf_pkg::DATA_W-1:0]   read_data_q;
	logic                          out_free;

	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.push) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			if (is_read_q) begin
				ack_kind_q  <= cnrf_pkg::ACK_READ_DATA;
				read_data_q <= in_range_q ? {rdata_hi, rdata_lo} : '0;
			end else begin
				ack_kind_q  <= empty_q ? cnrf_pkg::ACK_FILL_EMPTY : cnrf_pkg::ACK_FILL_DONE;
				read_data_q <= '0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign ack_kind  = ack_kind_q;
	assign read_data = read_data_q;

	assign sts.is_read  = is_read_q;
	assign sts.empty    = empty_q;
	assign sts.last_col = last_col;
	assign sts.last_row = last_row;
	assign sts.out_free = out_free;

	// Fill writes stay inside the store
	a_wr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.write |-> (32'(wr_addr) < 32'(cnrf_pkg::STORE_DEPTH)))
		else $error("fill write beyond store");

	// A result never overwrites one still waiting
	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> out_free)
		else $error("result pushed into full output register");

	// Every written byte gets at least one nibble
	a_nibble_en: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.write |-> (we_hi || we_lo))
		else $error("write cycle with no nibble enabled");

endmodule

`default_nettype wire

FILE: rtl/core/clipped_nibble_rect_fill.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Handshake             Word
// -------  --------------------  ------------------------------------------------
// in       in_valid / in_ready   action, left, top, width, height, colour,
//                                byte_address
// out      out_valid / out_ready ack_kind, read_data
//
// One word at a time. A fill goes through clip, setup, the byte writes and done
// from accept to a valid result, one byte per cycle on the single frame-store port.
// A read goes through clip, issue and done, an empty fill through clip, setup and
// done; the next word is accepted in idle, after the result is loaded.
// Reset clears control state only; the frame store is not cleared.
// The result sits in an output register; the next word is accepted while it
// waits, and the block holds in its done state if that register is still full.
module clipped_nibble_rect_fill (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic                                action,
	input  wire logic signed [cnrf_pkg::IN_W-1:0]    left,
	input  wire logic signed [cnrf_pkg::IN_W-1:0]    top,
	input  wire logic signed [cnrf_pkg::IN_W-1:0]    width,
	input  wire logic signed [cnrf_pkg::IN_W-1:0]    height,
	input  wire logic        [cnrf_pkg::NIB_W-1:0]   colour,
	input  wire logic        [cnrf_pkg::BADDR_W-1:0] byte_address,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic             [cnrf_pkg::KIND_W-1:0]  ack_kind,
	output logic             [cnrf_pkg::DATA_W-1:0]  read_data
);

	cnrf_pkg::cnrf_cmd_t cmd;
	cnrf_pkg::cnrf_sts_t sts;

	cnrf_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	cnrf_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.action      (action),
		.left        (left),
		.top         (top),
		.width       (width),
		.height      (height),
		.colour      (colour),
		.byte_address(byte_address),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.ack_kind    (ack_kind),
		.read_data   (read_data)
	);

endmodule

`default_nettype wire
